// ===== hw/rtl/sci_pkg.sv =====
// ----------------------------------------------------------------------------
// sci_pkg
// Shared widths, payload types and helper functions of the segment/circle
// intersection block.
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int W     = COORD_WIDTH;
	localparam int DW    = W + 1;          // coordinate differences
	localparam int PRW   = 2 * DW;         // products of differences
	localparam int SW    = 2 * W + 5;      // signed sums a, h, c, e
	localparam int MW    = 2 * W + 2;      // magnitudes of a, h, c
	localparam int NW    = 2 * W + 3;      // root numerator magnitude, multiplier width
	localparam int SQW   = 2 * W + 2;      // square root width
	localparam int QM    = 2 * SQW;        // radicand width
	localparam int PW    = 3 * W + 4;      // dividend width
	localparam int QDEPTH = 8;
	localparam int QAW   = $clog2(QDEPTH);
	localparam int QCW   = $clog2(QDEPTH + 1);
	localparam int IFW   = 3;              // in-flight count of the four front stages
	localparam int CNTW  = $clog2(PW + 1);

	localparam logic [CNTW-1:0] CNT_NW  = CNTW'(NW);
	localparam logic [CNTW-1:0] CNT_SQW = CNTW'(SQW);
	localparam logic [CNTW-1:0] CNT_PW  = CNTW'(PW);
	localparam logic [QCW-1:0]  QCNT_DEPTH = QCW'(QDEPTH);

	typedef struct packed {
		logic signed [W-1:0] start_x;
		logic signed [W-1:0] start_y;
		logic signed [W-1:0] end_x;
		logic signed [W-1:0] end_y;
		logic signed [W-1:0] center_x;
		logic signed [W-1:0] center_y;
		logic [W-2:0]        circle_radius;
	} item_t;

	typedef struct packed {
		logic [1:0]          hit_count;
		logic signed [W-1:0] first_x;
		logic signed [W-1:0] first_y;
		logic signed [W-1:0] second_x;
		logic signed [W-1:0] second_y;
	} result_t;

	typedef enum logic [1:0] {
		KIND_DEGEN    = 2'd0,
		KIND_START    = 2'd1,
		KIND_END      = 2'd2,
		KIND_INTERIOR = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [W-1:0]  sx;
		logic signed [W-1:0]  sy;
		logic signed [W-1:0]  ex;
		logic signed [W-1:0]  ey;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} geom_t;

	typedef struct packed {
		geom_t             g;
		kind_t             kind;
		logic              degen_hit;
		logic              cmp_zero;
		logic              cmp_pos;
		logic              in1;
		logic              in2;
		logic              c_neg;
		logic [MW-1:0]     a_mag;
		logic [MW-1:0]     h_mag;
		logic [MW-1:0]     c_mag;
		logic signed [MW:0] nh;
	} record_t;

	typedef struct packed {
		logic           empty;
		logic [QCW-1:0] count;
	} qstat_t;

	function automatic logic signed [SW-1:0] ext_sw(input logic signed [PRW-1:0] v);
		return SW'(v);
	endfunction

	function automatic logic signed [SW-1:0] ext_r2(input logic [2*W-3:0] v);
		return {{(SW-2*W+2){1'b0}}, v};
	endfunction

endpackage

// ===== hw/rtl/sci_front.sv =====
// ----------------------------------------------------------------------------
// sci_front
// Four-stage front: differences, products, sums, then classification of the
// item into a record for the back end.
// ----------------------------------------------------------------------------
module sci_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sci_pkg::item_t    in_item,
	output logic              push,
	output sci_pkg::record_t  push_rec,
	output logic [sci_pkg::IFW-1:0] inflight
);

	logic v_s1, v_s2, v_s3, v_s4;

	sci_pkg::geom_t g_s1, g_s2, g_s3;
	logic signed [sci_pkg::DW-1:0] fx_s1, fy_s1;
	logic [sci_pkg::W-2:0] rad_s1;
	logic degen_s1, degen_s2, degen_s3;

	logic signed [sci_pkg::PRW-1:0] pxx_s2, pyy_s2, dxx_s2, dyy_s2, fxd_s2, fyd_s2;
	logic [2*sci_pkg::W-3:0] r2_s2;

	logic signed [sci_pkg::SW-1:0] a_s3, h_s3, f2_s3, r2_s3;

	sci_pkg::record_t rec_s4;

	logic signed [sci_pkg::SW-1:0] c_c, ah_c, e_c, nh_c, hmag_c, cmag_c;
	logic h_pos, c_le, c_ge, e_le, e_ge, ah_neg;
	sci_pkg::record_t rec_c;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		g_s1.sx  <= in_item.start_x;
		g_s1.sy  <= in_item.start_y;
		g_s1.ex  <= in_item.end_x;
		g_s1.ey  <= in_item.end_y;
		g_s1.dx  <= {in_item.end_x[sci_pkg::W-1], in_item.end_x}
			- {in_item.start_x[sci_pkg::W-1], in_item.start_x};
		g_s1.dy  <= {in_item.end_y[sci_pkg::W-1], in_item.end_y}
			- {in_item.start_y[sci_pkg::W-1], in_item.start_y};
		fx_s1    <= {in_item.start_x[sci_pkg::W-1], in_item.start_x}
			- {in_item.center_x[sci_pkg::W-1], in_item.center_x};
		fy_s1    <= {in_item.start_y[sci_pkg::W-1], in_item.start_y}
			- {in_item.center_y[sci_pkg::W-1], in_item.center_y};
		rad_s1   <= in_item.circle_radius;
		degen_s1 <= (in_item.start_x == in_item.end_x) && (in_item.start_y == in_item.end_y);
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		g_s2     <= g_s1;
		degen_s2 <= degen_s1;
		pxx_s2   <= fx_s1 * fx_s1;
		pyy_s2   <= fy_s1 * fy_s1;
		dxx_s2   <= g_s1.dx * g_s1.dx;
		dyy_s2   <= g_s1.dy * g_s1.dy;
		fxd_s2   <= fx_s1 * g_s1.dx;
		fyd_s2   <= fy_s1 * g_s1.dy;
		r2_s2    <= rad_s1 * rad_s1;
	end

	// stage 3: a = |d|^2, h = f.d, |f|^2
	always_ff @(posedge clk) begin
		g_s3     <= g_s2;
		degen_s3 <= degen_s2;
		a_s3     <= sci_pkg::ext_sw(dxx_s2) + sci_pkg::ext_sw(dyy_s2);
		h_s3     <= sci_pkg::ext_sw(fxd_s2) + sci_pkg::ext_sw(fyd_s2);
		f2_s3    <= sci_pkg::ext_sw(pxx_s2) + sci_pkg::ext_sw(pyy_s2);
		r2_s3    <= sci_pkg::ext_r2(r2_s2);
	end

	// stage 4: c, e and classification
	always_comb begin
		c_c    = f2_s3 - r2_s3;
		ah_c   = a_s3 + h_s3;
		e_c    = ah_c + h_s3 + c_c;
		nh_c   = -h_s3;
		hmag_c = h_s3[sci_pkg::SW-1] ? nh_c : h_s3;
		cmag_c = c_c[sci_pkg::SW-1] ? -c_c : c_c;
		h_pos  = !h_s3[sci_pkg::SW-1] && (h_s3 != '0);
		c_le   = c_c[sci_pkg::SW-1] || (c_c == '0);
		c_ge   = !c_c[sci_pkg::SW-1];
		e_le   = e_c[sci_pkg::SW-1] || (e_c == '0);
		e_ge   = !e_c[sci_pkg::SW-1];
		ah_neg = ah_c[sci_pkg::SW-1];

		rec_c.g         = g_s3;
		rec_c.degen_hit = (c_c == '0);
		rec_c.c_neg     = c_c[sci_pkg::SW-1];
		rec_c.a_mag     = a_s3[sci_pkg::MW-1:0];
		rec_c.h_mag     = hmag_c[sci_pkg::MW-1:0];
		rec_c.c_mag     = cmag_c[sci_pkg::MW-1:0];
		rec_c.nh        = nh_c[sci_pkg::MW:0];
		rec_c.in1       = (!h_pos || c_le) && !ah_neg && e_ge;
		rec_c.in2       = (!h_pos && c_ge) && (!ah_neg || e_le);
		if (degen_s3) begin
			rec_c.kind     = sci_pkg::KIND_DEGEN;
			rec_c.cmp_zero = (c_c == '0);
			rec_c.cmp_pos  = !c_le;
		end else if (h_pos) begin
			rec_c.kind     = sci_pkg::KIND_START;
			rec_c.cmp_zero = (c_c == '0);
			rec_c.cmp_pos  = !c_le;
		end else if (ah_neg) begin
			rec_c.kind     = sci_pkg::KIND_END;
			rec_c.cmp_zero = (e_c == '0);
			rec_c.cmp_pos  = !e_le;
		end else begin
			rec_c.kind     = sci_pkg::KIND_INTERIOR;
			rec_c.cmp_zero = 1'b0;
			rec_c.cmp_pos  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rec_s4 <= rec_c;
	end

	assign push     = v_s4;
	assign push_rec = rec_s4;
	assign inflight = {2'b00, v_s1} + {2'b00, v_s2} + {2'b00, v_s3} + {2'b00, v_s4};

endmodule

// ===== hw/rtl/sci_queue.sv =====
// ----------------------------------------------------------------------------
// sci_queue
// Record queue between the front and the back end.
// ----------------------------------------------------------------------------
module sci_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sci_pkg::record_t  push_rec,
	input  logic              pop,
	output sci_pkg::record_t  head_rec,
	output sci_pkg::qstat_t   stat
);

	sci_pkg::record_t mem_q [sci_pkg::QDEPTH];
	logic [sci_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sci_pkg::QCW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_rec   = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < sci_pkg::QCNT_DEPTH))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

endmodule

// ===== hw/rtl/sci_back.sv =====
// ----------------------------------------------------------------------------
// sci_back
// Back end sequencer: discriminant, square root and point coordinates through
// a shared shift-add multiplier, a digit square root and a restoring divider.
// ----------------------------------------------------------------------------
module sci_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	input  sci_pkg::record_t  rec,
	output logic              pop,
	output logic              done,
	output sci_pkg::result_t  result
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CLASS  = 9'b000000010,
		ST_MUL_HH = 9'b000000100,
		ST_MUL_AC = 9'b000001000,
		ST_SQRT   = 9'b000010000,
		ST_PT_SEL = 9'b000100000,
		ST_PT_MUL = 9'b001000000,
		ST_PT_DIV = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic   done_q;
	logic [sci_pkg::CNTW-1:0] cnt_q;
	logic   sel_q, axis_q, slot_q, neg_q;

	sci_pkg::record_t rec_q;
	sci_pkg::result_t res_q;

	logic [sci_pkg::NW-1:0]   mula_q, hi_q, lo_q;
	logic [2*sci_pkg::NW-1:0] hh_q;
	logic [sci_pkg::QM-1:0]   rad_q;
	logic [sci_pkg::SQW:0]    srem_q;
	logic [sci_pkg::SQW-1:0]  root_q;
	logic [sci_pkg::MW-1:0]   drem_q;
	logic [sci_pkg::PW-1:0]   dnum_q;

	// multiplier step
	logic [sci_pkg::NW:0]     msum;
	logic [2*sci_pkg::NW-1:0] prod;
	// discriminant
	logic [2*sci_pkg::NW:0]   q_c;
	// square root step
	logic [sci_pkg::SQW+1:0]  srem_n, strial, sdiff;
	logic                     sge;
	// divider step
	logic [sci_pkg::MW:0]     drem_n;
	logic                     dge;
	// root numerators
	logic signed [sci_pkg::NW:0] n1_c, n2_c, n_c, nabs_c;
	logic                     job_en;
	logic signed [sci_pkg::DW-1:0] d_c, dabs_c;
	// coordinate
	logic [sci_pkg::W-1:0]    quot_w, off_w, base_w, coord_w;

	always_comb begin
		msum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mula_q} : '0);
		prod   = {hi_q, lo_q};
		q_c    = rec_q.c_neg ? ({1'b0, hh_q} + {1'b0, prod}) : ({1'b0, hh_q} - {1'b0, prod});

		srem_n = {srem_q[sci_pkg::SQW-1:0], rad_q[sci_pkg::QM-1:sci_pkg::QM-2]};
		strial = {root_q, 2'b01};
		sge    = (srem_n >= strial);
		sdiff  = srem_n - strial;

		drem_n = {drem_q, dnum_q[sci_pkg::PW-1]};
		dge    = (drem_n >= {1'b0, rec_q.a_mag});

		n1_c   = {{(sci_pkg::NW-sci_pkg::MW){rec_q.nh[sci_pkg::MW]}}, rec_q.nh}
			+ $signed({{(sci_pkg::NW+1-sci_pkg::SQW){1'b0}}, root_q});
		n2_c   = {{(sci_pkg::NW-sci_pkg::MW){rec_q.nh[sci_pkg::MW]}}, rec_q.nh}
			- $signed({{(sci_pkg::NW+1-sci_pkg::SQW){1'b0}}, root_q});
		n_c    = sel_q ? n2_c : n1_c;
		nabs_c = n_c[sci_pkg::NW] ? -n_c : n_c;
		job_en = sel_q ? rec_q.in2 : rec_q.in1;
		d_c    = axis_q ? rec_q.g.dy : rec_q.g.dx;
		dabs_c = d_c[sci_pkg::DW-1] ? -d_c : d_c;

		quot_w  = dnum_q[sci_pkg::W-1:0];
		off_w   = neg_q ? -quot_w : quot_w;
		base_w  = axis_q ? rec_q.g.sy : rec_q.g.sx;
		coord_w = base_w + off_w;
	end

	assign pop = (state_q == ST_IDLE) && rec_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						rec_q   <= rec;
						res_q   <= '0;
						sel_q   <= 1'b0;
						axis_q  <= 1'b0;
						slot_q  <= 1'b0;
						root_q  <= '0;
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					// multiplier preset for h^2, used unless decided here
					mula_q <= {{(sci_pkg::NW-sci_pkg::MW){1'b0}}, rec_q.h_mag};
					lo_q   <= {{(sci_pkg::NW-sci_pkg::MW){1'b0}}, rec_q.h_mag};
					hi_q   <= '0;
					cnt_q  <= '0;
					case (rec_q.kind)
						sci_pkg::KIND_DEGEN: begin
							if (rec_q.degen_hit) begin
								res_q.hit_count <= 2'd1;
								res_q.first_x   <= rec_q.g.sx;
								res_q.first_y   <= rec_q.g.sy;
							end
							state_q <= ST_EMIT;
						end
						sci_pkg::KIND_START: begin
							if (rec_q.cmp_zero) begin
								res_q.hit_count <= 2'd1;
								res_q.first_x   <= rec_q.g.sx;
								res_q.first_y   <= rec_q.g.sy;
								state_q <= ST_EMIT;
							end else if (rec_q.cmp_pos) begin
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_MUL_HH;
							end
						end
						sci_pkg::KIND_END: begin
							if (rec_q.cmp_zero) begin
								res_q.hit_count <= 2'd1;
								res_q.first_x   <= rec_q.g.ex;
								res_q.first_y   <= rec_q.g.ey;
								state_q <= ST_EMIT;
							end else if (rec_q.cmp_pos) begin
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_MUL_HH;
							end
						end
						default: state_q <= ST_MUL_HH;
					endcase
				end
				ST_MUL_HH: begin
					if (cnt_q != sci_pkg::CNT_NW) begin
						hi_q  <= msum[sci_pkg::NW:1];
						lo_q  <= {msum[0], lo_q[sci_pkg::NW-1:1]};
						cnt_q <= cnt_q + 1'b1;
					end else begin
						hh_q    <= prod;
						mula_q  <= {{(sci_pkg::NW-sci_pkg::MW){1'b0}}, rec_q.a_mag};
						lo_q    <= {{(sci_pkg::NW-sci_pkg::MW){1'b0}}, rec_q.c_mag};
						hi_q    <= '0;
						cnt_q   <= '0;
						state_q <= ST_MUL_AC;
					end
				end
				ST_MUL_AC: begin
					if (cnt_q != sci_pkg::CNT_NW) begin
						hi_q  <= msum[sci_pkg::NW:1];
						lo_q  <= {msum[0], lo_q[sci_pkg::NW-1:1]};
						cnt_q <= cnt_q + 1'b1;
					end else begin
						rad_q  <= q_c[sci_pkg::QM-1:0];
						srem_q <= '0;
						cnt_q  <= '0;
						if (q_c[2*sci_pkg::NW]) begin
							// negative discriminant: miss
							state_q <= ST_EMIT;
						end else if ((rec_q.kind == sci_pkg::KIND_INTERIOR) && (q_c == '0)) begin
							// tangent at the foot of the perpendicular
							rec_q.in1 <= 1'b1;
							rec_q.in2 <= 1'b0;
							state_q   <= ST_PT_SEL;
						end else begin
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (cnt_q != sci_pkg::CNT_SQW) begin
						rad_q  <= {rad_q[sci_pkg::QM-3:0], 2'b00};
						srem_q <= sge ? sdiff[sci_pkg::SQW:0] : srem_n[sci_pkg::SQW:0];
						root_q <= {root_q[sci_pkg::SQW-2:0], sge};
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_PT_SEL;
					end
				end
				ST_PT_SEL: begin
					if (!job_en) begin
						if (sel_q) begin
							state_q <= ST_EMIT;
						end else begin
							sel_q <= 1'b1;
						end
					end else begin
						mula_q  <= nabs_c[sci_pkg::NW-1:0];
						lo_q    <= {{(sci_pkg::NW-sci_pkg::DW){1'b0}}, dabs_c};
						hi_q    <= '0;
						neg_q   <= n_c[sci_pkg::NW] ^ d_c[sci_pkg::DW-1];
						cnt_q   <= '0;
						state_q <= ST_PT_MUL;
					end
				end
				ST_PT_MUL: begin
					if (cnt_q != sci_pkg::CNT_NW) begin
						hi_q  <= msum[sci_pkg::NW:1];
						lo_q  <= {msum[0], lo_q[sci_pkg::NW-1:1]};
						cnt_q <= cnt_q + 1'b1;
					end else begin
						dnum_q  <= prod[sci_pkg::PW-1:0];
						drem_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_PT_DIV;
					end
				end
				ST_PT_DIV: begin
					if (cnt_q != sci_pkg::CNT_PW) begin
						drem_q <= dge ? (drem_n[sci_pkg::MW-1:0] - rec_q.a_mag)
							: drem_n[sci_pkg::MW-1:0];
						dnum_q <= {dnum_q[sci_pkg::PW-2:0], dge};
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						case ({slot_q, axis_q})
							2'b00:   res_q.first_x  <= coord_w;
							2'b01:   res_q.first_y  <= coord_w;
							2'b10:   res_q.second_x <= coord_w;
							default: res_q.second_y <= coord_w;
						endcase
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= ST_PT_SEL;
						end else begin
							axis_q          <= 1'b0;
							slot_q          <= 1'b1;
							res_q.hit_count <= slot_q ? 2'd2 : 2'd1;
							if (sel_q) begin
								state_q <= ST_EMIT;
							end else begin
								sel_q   <= 1'b1;
								state_q <= ST_PT_SEL;
							end
						end
					end
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.hit_count != 2'd3))
		else $error("hit count out of range");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_CLASS))
		else $error("popped item not classified");

endmodule

// ===== hw/rtl/segment_circle_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersect
// Intersection points of a line segment with a circle, signed fixed point.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A four-stage front
// forms the differences, the squared lengths and the dot product and sorts the
// item (degenerate, closest point at an end, closest point inside); an
// eight-entry queue then feeds the back end, which works one item at a time.
// There a shift-add multiplier (one bit per cycle) forms h*h and a*c, a digit
// square root takes one bit per cycle, and each coordinate takes one multiply
// and one restoring divide of one bit per cycle. An item decided by the front
// (degenerate, end point on the circle or miss) takes the least time, one that misses
// after the discriminant takes longer, and one with two points the longest; the
// back end sets the sustained rate, while up to nine items can be taken back to
// back before busy rises. Each result is shown for exactly one cycle with done
// high and must be taken then: the receiver cannot hold results off. Coordinates
// beyond hit_count points read as zero.
// ----------------------------------------------------------------------------
module segment_circle_intersect (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sci_pkg::item_t   item,
	output logic             done,
	output sci_pkg::result_t result
);

	logic                    push, pop, accept;
	sci_pkg::record_t        push_rec, head_rec;
	sci_pkg::qstat_t         qstat;
	logic [sci_pkg::IFW-1:0] inflight;
	logic [sci_pkg::QCW:0]   occ;

	// queue entries plus items still in the front must leave room for one more
	assign occ    = {1'b0, qstat.count} + {{(sci_pkg::QCW+1-sci_pkg::IFW){1'b0}}, inflight};
	assign busy   = (occ >= {1'b0, sci_pkg::QCNT_DEPTH});
	assign accept = start && !busy;

	sci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (item),
		.push     (push),
		.push_rec (push_rec),
		.inflight (inflight)
	);

	sci_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.stat     (qstat)
	);

	sci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (!qstat.empty),
		.rec       (head_rec),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== verif/segment_circle_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersect_tb
// Self-checking bench for the segment/circle intersection block.
// ----------------------------------------------------------------------------
// A queue of segment/circle queries is filled by directed cases and then by
// random ones. A clocked driver offers them on start/busy with random gaps
// or in gapless bursts. A clocked monitor checks each done strobe against an
// exact wide-integer prediction of the hit count and the hit points.
// ----------------------------------------------------------------------------
module segment_circle_intersect_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0]        uwide_t;

	localparam int ONE = 65536;          // 1.0 in Q16.16
	localparam int NUM_RANDOM = 1425;
	localparam int MAX_GAP = 18;
	localparam int DRAIN_CYCLES = 1500;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	sci_pkg::item_t   item = '0;
	logic             busy;
	logic             done;
	sci_pkg::result_t result;

	sci_pkg::item_t   query_q[$];     // queries waiting to be offered
	sci_pkg::result_t hits_q[$];      // predicted results, oldest first
	int      gap_left = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_errors = 0;
	int      n_by_count[3] = '{0, 0, 0};
	bit      burst_mode = 1'b0;

	segment_circle_intersect DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// exact prediction
	// ------------------------------------------------------------------------
	function automatic int sign_of(wide_t v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	function automatic wide_t floor_sqrt(wide_t v);
		uwide_t root, cand;
		root = '0;
		for (int k = 127; k >= 0; k--) begin
			cand = root | (uwide_t'(1) << k);
			if (cand * cand <= uwide_t'(v))
				root = cand;
		end
		return wide_t'(root);
	endfunction

	// point along the segment: base + trunc(num * delta / len2), low bits kept
	function automatic logic [31:0] point_along(wide_t base, wide_t num, wide_t delta,
			wide_t len2);
		wide_t v;
		v = base + (num * delta) / len2;
		return v[31:0];
	endfunction

	function automatic sci_pkg::result_t predict_hits(sci_pkg::item_t q);
		sci_pkg::result_t r;
		wide_t sx, sy, ex, ey, cx, cy, rad, fx, fy, r2, c;
		wide_t dx, dy, a, h, e, nh, cr, disc, root, n1, n2;
		logic [31:0] px, py;
		int cmpv;
		bit ahpos, in1, in2;
		int k;
		r = '0;
		sx = {{224{q.start_x[31]}}, q.start_x};
		sy = {{224{q.start_y[31]}}, q.start_y};
		ex = {{224{q.end_x[31]}}, q.end_x};
		ey = {{224{q.end_y[31]}}, q.end_y};
		cx = {{224{q.center_x[31]}}, q.center_x};
		cy = {{224{q.center_y[31]}}, q.center_y};
		rad = {225'b0, q.circle_radius};
		fx = sx - cx;
		fy = sy - cy;
		r2 = rad * rad;
		c = fx * fx + fy * fy - r2;

		// degenerate segment: only a point exactly on the circle counts
		if (sx == ex && sy == ey) begin
			if (c == 0) begin
				r.hit_count = 2'd1;
				r.first_x = q.start_x;
				r.first_y = q.start_y;
			end
			return r;
		end

		dx = ex - sx;
		dy = ey - sy;
		a = dx * dx + dy * dy;
		h = fx * dx + fy * dy;
		e = a + h + h + c;
		nh = -h;

		// closest point: start, end or foot of the perpendicular
		if (h > 0) begin
			cmpv = sign_of(c);
			px = q.start_x;
			py = q.start_y;
		end else if (a + h < 0) begin
			cmpv = sign_of(e);
			px = q.end_x;
			py = q.end_y;
		end else begin
			cr = fx * dy - fy * dx;
			cmpv = sign_of(cr * cr - r2 * a);
			px = point_along(sx, nh, dx, a);
			py = point_along(sy, nh, dy, a);
		end

		if (cmpv == 0) begin
			r.hit_count = 2'd1;
			r.first_x = px;
			r.first_y = py;
			return r;
		end
		if (cmpv > 0)
			return r;

		disc = h * h - a * c;
		if (disc < 0)
			return r;
		root = floor_sqrt(disc);
		ahpos = !(a + h < 0);
		in1 = (h <= 0 || c <= 0) && ahpos && e >= 0;
		in2 = (h <= 0 && c >= 0) && (ahpos || e <= 0);
		n1 = nh + root;
		n2 = nh - root;
		k = 0;
		if (in1) begin
			r.first_x = point_along(sx, n1, dx, a);
			r.first_y = point_along(sy, n1, dy, a);
			k = 1;
		end
		if (in2) begin
			if (k == 0) begin
				r.first_x = point_along(sx, n2, dx, a);
				r.first_y = point_along(sy, n2, dy, a);
			end else begin
				r.second_x = point_along(sx, n2, dx, a);
				r.second_y = point_along(sy, n2, dy, a);
			end
			k++;
		end
		r.hit_count = 2'(k);
		return r;
	endfunction

	function automatic sci_pkg::item_t make_query(int sx, int sy, int ex, int ey, int cx,
			int cy, int rad);
		sci_pkg::item_t q;
		q.start_x = sx;
		q.start_y = sy;
		q.end_x = ex;
		q.end_y = ey;
		q.center_x = cx;
		q.center_y = cy;
		q.circle_radius = rad[30:0];
		return q;
	endfunction

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string field, int unsigned want, int unsigned got);
		$display("mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
			n_checked, field, want, got);
		n_errors++;
	endtask

	// ------------------------------------------------------------------------
	// driver: one item offered per start; outside bursts a new gap is drawn after each item
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else begin
			if (!start || !busy) begin
				gap = 0;
				if (start) begin
					// the item on the bus was taken at this edge
					hits_q.push_back(predict_hits(item));
					n_sent++;
					if (!burst_mode)
						gap = $urandom_range(0, MAX_GAP);
				end
				if (gap > 0) begin
					gap_left <= gap - 1;
					start <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (query_q.size() > 0) begin
					item <= query_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// bursts with no gaps alternate with stretches of random gaps
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			burst_mode <= ~burst_mode;
	end

	// ------------------------------------------------------------------------
	// monitor: every done strobe must match the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		sci_pkg::result_t want;
		if (arst_n && done) begin
			if (hits_q.size() == 0) begin
				$display("unexpected result: hit_count %0d", result.hit_count);
				n_errors++;
			end else begin
				want = hits_q.pop_front();
				if (result.hit_count !== want.hit_count)
					report_mismatch("hit_count", want.hit_count, result.hit_count);
				if (result.first_x !== want.first_x)
					report_mismatch("first_x", want.first_x, result.first_x);
				if (result.first_y !== want.first_y)
					report_mismatch("first_y", want.first_y, result.first_y);
				if (result.second_x !== want.second_x)
					report_mismatch("second_x", want.second_x, result.second_x);
				if (result.second_y !== want.second_y)
					report_mismatch("second_y", want.second_y, result.second_y);
				if (want.hit_count <= 2)
					n_by_count[want.hit_count]++;
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int cx, cy, rad, span, kind;
		int lo_max, hi_min;
		lo_max = 32'h7fff_ffff;
		hi_min = 32'h8000_0000;

		// directed queries
		// degenerate point on the circle, then off it
		query_q.push_back(make_query(3 * ONE, 0, 3 * ONE, 0, 0, 0, 3 * ONE));
		query_q.push_back(make_query(ONE, ONE, ONE, ONE, 0, 0, 3 * ONE));
		// horizontal tangent, foot inside the segment
		query_q.push_back(make_query(-5 * ONE, 2 * ONE, 5 * ONE, 2 * ONE, 0, 0, 2 * ONE));
		// one hit exactly at the start point and at the end point
		query_q.push_back(make_query(2 * ONE, 0, 6 * ONE, 0, 0, 0, 2 * ONE));
		query_q.push_back(make_query(6 * ONE, 0, 2 * ONE, 0, 0, 0, 2 * ONE));
		// far from the circle
		query_q.push_back(make_query(-5 * ONE, 9 * ONE, 5 * ONE, 9 * ONE, 0, 0, 2 * ONE));
		// across the circle, the second through the center: two hits, both directions
		query_q.push_back(make_query(-5 * ONE, ONE / 3, 5 * ONE, -ONE / 7, 0, 0, 2 * ONE));
		query_q.push_back(make_query(4 * ONE, 3 * ONE, -4 * ONE, -3 * ONE, 0, 0, 2 * ONE));
		// one end inside: one hit, both directions
		query_q.push_back(make_query(0, 0, 7 * ONE, 5 * ONE, ONE, 0, 3 * ONE));
		query_q.push_back(make_query(7 * ONE, 5 * ONE, 0, 0, ONE, 0, 3 * ONE));
		// whole segment inside: no hit
		query_q.push_back(make_query(-ONE, 0, ONE, ONE, 0, 0, 9 * ONE));
		// line crosses the circle but the segment stops short
		query_q.push_back(make_query(-9 * ONE, 0, -5 * ONE, 0, 0, 0, 2 * ONE));
		// zero radius, point on the segment and off it
		query_q.push_back(make_query(-ONE, 0, ONE, 0, 0, 0, 0));
		query_q.push_back(make_query(-ONE, 0, ONE, 0, 0, 1, 0));
		// field extremes
		query_q.push_back(make_query(hi_min, hi_min, lo_max, lo_max, 0, 0, lo_max));
		query_q.push_back(make_query(lo_max, hi_min, hi_min, lo_max, hi_min, lo_max, lo_max));
		query_q.push_back(make_query(hi_min, lo_max, hi_min, hi_min, lo_max, 0, lo_max));
		query_q.push_back(make_query(lo_max, lo_max, lo_max, lo_max, hi_min, hi_min, lo_max));
		query_q.push_back(make_query(hi_min, hi_min, hi_min, hi_min, hi_min, hi_min, 0));
		query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(-1, -1, 1, 1, 0, 0, 1));

		// random queries
		for (int n = 0; n < NUM_RANDOM; n++) begin
			kind = $urandom_range(0, 99);
			cx = int'($urandom_range(0, 1 << 24)) - (1 << 23);
			cy = int'($urandom_range(0, 1 << 24)) - (1 << 23);
			rad = $urandom_range(1, 1 << 21);
			span = 2 * rad;
			if (kind < 55) begin
				// near the circle: mostly crossings with random content
				query_q.push_back(make_query(
					cx + int'($urandom_range(0, 2 * span)) - span,
					cy + int'($urandom_range(0, 2 * span)) - span,
					cx + int'($urandom_range(0, 2 * span)) - span,
					cy + int'($urandom_range(0, 2 * span)) - span,
					cx, cy, rad));
			end else if (kind < 62) begin
				// tangent line above the center
				query_q.push_back(make_query(cx - int'($urandom_range(0, span)),
					cy + rad, cx + int'($urandom_range(0, span)), cy + rad, cx, cy, rad));
			end else if (kind < 68) begin
				// vertical tangent at the side
				query_q.push_back(make_query(cx - rad, cy - int'($urandom_range(0, span)),
					cx - rad, cy + int'($urandom_range(0, span)), cx, cy, rad));
			end else if (kind < 74) begin
				// degenerate or very short, on the circle or just beside it
				query_q.push_back(make_query(cx + rad, cy + int'($urandom_range(0, 1)),
					cx + rad, cy + int'($urandom_range(0, 1)), cx, cy, rad));
			end else begin
				// full range noise
				query_q.push_back(make_query($urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (query_q.size() > 0 || start || hits_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d queries sent, %0d results checked", n_sent, n_checked);
		$display("results with 0/1/2 hits: %0d/%0d/%0d",
			n_by_count[0], n_by_count[1], n_by_count[2]);
		if (n_errors == 0 && hits_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, hits_q.size());
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#40_000_000;
		$display("timeout with %0d results outstanding", hits_q.size());
		$display("FAILURE");
		$finish;
	end

endmodule
